// ----- hdl/kcxs_pkg.sv -----
// ----------------------------------------------------------------------------
// kcxs_pkg
// Shared types and constants for the k-closest XOR distance selector.
// ----------------------------------------------------------------------------
package kcxs_pkg;

  localparam int SCORE_W = 16;
  localparam int DIST_W  = 32;
  localparam int RANK_W  = 4;
  localparam int RES_W   = 5;
  localparam int KEEP_W  = 5;
  localparam int RES_MAX = 16;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // register select is paddr[2]
  localparam logic REG_REF_HEIGHT = 1'b0;
  localparam logic REG_KEEP_COUNT = 1'b1;

  localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(16);

  typedef struct packed {
    logic                      valid;
    logic [DIST_W-1:0]         distance;
    logic signed [SCORE_W-1:0] score;
  } cell_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

endpackage

// ----- hdl/k_closest_xor_select.sv -----
// ----------------------------------------------------------------------------
// k_closest_xor_select
// Keeps the K_MAX smallest distinct XOR distances of a set of scores and
// emits the closest ones, in ascending order, at the end of the set.
// ----------------------------------------------------------------------------
// While a set is being collected one score is accepted every cycle: a row of
// K_MAX cells compares the new distance against every held entry at once and
// shifts the larger ones right in the same cycle. After the score flagged
// set_end the input is stalled while the results are shifted out of the
// head cell, one per cycle unless out_stall_i holds them back; min(held
// entries, keep_count, RES_MAX) results are given (at least one); the next
// set can start the cycle after the last transfer. Scores whose distance is already held are dropped.
module k_closest_xor_select #(
  parameter int K_MAX = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [kcxs_pkg::PADDR_W-1:0]         paddr,
  input  logic [kcxs_pkg::PDATA_W-1:0]         pwdata,
  output logic [kcxs_pkg::PDATA_W-1:0]         prdata,
  output logic                                 pready,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [kcxs_pkg::SCORE_W-1:0]  score_i,
  input  logic                                 set_end_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [kcxs_pkg::SCORE_W-1:0]  chosen_score_o,
  output logic [kcxs_pkg::DIST_W-1:0]          chosen_distance_o,
  output logic [kcxs_pkg::RANK_W-1:0]          rank_o,
  output logic                                 entry_valid_o,
  output logic                                 run_end_o
);
  import kcxs_pkg::*;

  localparam int CNT_W = $clog2(K_MAX + 1);
  localparam int CMP_W = (CNT_W > RES_W) ? CNT_W : RES_W;

  // configuration
  logic [DIST_W-1:0] ref_height_q;
  logic [KEEP_W-1:0] keep_count_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_height_q <= '0;
      keep_count_q <= KEEP_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_REF_HEIGHT: ref_height_q <= pwdata[DIST_W-1:0];
        REG_KEEP_COUNT: keep_count_q <= pwdata[KEEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_REF_HEIGHT: prdata = PDATA_W'(ref_height_q);
      REG_KEEP_COUNT: prdata = PDATA_W'(keep_count_q);
      default: prdata = '0;
    endcase
  end

  // control
  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [RES_W-1:0]   n_q, n_d;
  logic [RANK_W-1:0]  rank_q, rank_d;

  logic               in_xfer, out_xfer, last_out;
  logic               dup, insert, clear;
  logic [DIST_W-1:0]  new_dist;
  logic [CNT_W-1:0]   new_count;
  logic [RES_W-1:0]   limit;
  logic [CMP_W-1:0]   new_count_x, limit_x;

  cell_t              cells   [K_MAX];
  cell_t              prev_c  [K_MAX];
  cell_t              next_c  [K_MAX];
  logic [K_MAX-1:0]   lt, eq, prev_lt;

  assign new_dist = ref_height_q ^ {{(DIST_W - SCORE_W){score_i[SCORE_W-1]}}, score_i};

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);
  assign in_xfer     = in_valid_i && (state_q == ST_IDLE);
  assign out_xfer    = out_valid_o && !out_stall_i;
  assign last_out    = ({1'b0, rank_q} + RES_W'(1)) == n_q;

  assign dup    = |eq;
  assign insert = in_xfer && !dup;
  assign clear  = out_xfer && last_out;

  always_comb begin
    new_count = count_q;
    if (insert && !lt[K_MAX-1] && (32'(count_q) < K_MAX)) begin
      new_count = count_q + CNT_W'(1);
    end
  end

  always_comb begin
    if (keep_count_q == '0) begin
      limit = RES_W'(1);
    end else if (32'(keep_count_q) > RES_MAX) begin
      limit = RES_W'(RES_MAX);
    end else begin
      limit = RES_W'(keep_count_q);
    end
    if (32'(limit) > K_MAX) begin
      limit = RES_W'(K_MAX);
    end
  end

  assign new_count_x = CMP_W'(new_count);
  assign limit_x     = CMP_W'(limit);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    n_d     = n_q;
    rank_d  = rank_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          count_d = new_count;
          if (set_end_i) begin
            rank_d  = '0;
            state_d = ST_EMIT;
            if (new_count == '0) begin
              n_d = RES_W'(1);
            end else if (new_count_x < limit_x) begin
              n_d = RES_W'(new_count);
            end else begin
              n_d = limit;
            end
          end
        end
      end
      ST_EMIT: begin
        if (out_xfer) begin
          rank_d = rank_q + RANK_W'(1);
          if (last_out) begin
            count_d = '0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      n_q     <= '0;
      rank_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      n_q     <= n_d;
      rank_q  <= rank_d;
    end
  end

  // cell row
  for (genvar i = 0; i < K_MAX; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_c[i]  = '0;
      assign prev_lt[i] = 1'b1;
    end else begin : g_body
      assign prev_c[i]  = cells[i-1];
      assign prev_lt[i] = lt[i-1];
    end
    if (i == K_MAX - 1) begin : g_tail
      assign next_c[i] = '0;
    end else begin : g_inner
      assign next_c[i] = cells[i+1];
    end

    kcxs_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .clear_i     (clear),
      .insert_i    (insert),
      .shift_i     (out_xfer),
      .new_dist_i  (new_dist),
      .new_score_i (score_i),
      .prev_i      (prev_c[i]),
      .prev_lt_i   (prev_lt[i]),
      .next_i      (next_c[i]),
      .cell_o      (cells[i]),
      .lt_o        (lt[i]),
      .eq_o        (eq[i])
    );
  end

  // output taken from the head cell
  assign entry_valid_o     = cells[0].valid;
  assign chosen_score_o    = cells[0].valid ? cells[0].score : '0;
  assign chosen_distance_o = cells[0].valid ? cells[0].distance : '0;
  assign rank_o            = rank_q;
  assign run_end_o         = last_out;

endmodule

// ----- hdl/kcxs_cell.sv -----
// ----------------------------------------------------------------------------
// kcxs_cell
// One slot of the sorted list: compares the incoming distance, takes the new
// entry, its left neighbor's entry or its right neighbor's entry.
// ----------------------------------------------------------------------------
module kcxs_cell (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               clear_i,
  input  logic                               insert_i,
  input  logic                               shift_i,
  input  logic [kcxs_pkg::DIST_W-1:0]        new_dist_i,
  input  logic signed [kcxs_pkg::SCORE_W-1:0] new_score_i,
  input  kcxs_pkg::cell_t                    prev_i,
  input  logic                               prev_lt_i,
  input  kcxs_pkg::cell_t                    next_i,
  output kcxs_pkg::cell_t                    cell_o,
  output logic                               lt_o,
  output logic                               eq_o
);
  import kcxs_pkg::*;

  logic                      valid_q, valid_d;
  logic [DIST_W-1:0]         dist_q, dist_d;
  logic signed [SCORE_W-1:0] score_q, score_d;
  logic                      load;

  assign lt_o = valid_q && (dist_q < new_dist_i);
  assign eq_o = valid_q && (dist_q == new_dist_i);

  always_comb begin
    valid_d = valid_q;
    dist_d  = dist_q;
    score_d = score_q;
    load    = 1'b0;
    if (clear_i) begin
      valid_d = 1'b0;
    end else if (shift_i) begin
      valid_d = next_i.valid;
      dist_d  = next_i.distance;
      score_d = next_i.score;
      load    = 1'b1;
    end else if (insert_i && !lt_o) begin
      load = 1'b1;
      if (prev_lt_i) begin
        valid_d = 1'b1;
        dist_d  = new_dist_i;
        score_d = new_score_i;
      end else begin
        valid_d = prev_i.valid;
        dist_d  = prev_i.distance;
        score_d = prev_i.score;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      dist_q  <= dist_d;
      score_q <= score_d;
    end
  end

  assign cell_o = '{valid: valid_q, distance: dist_q, score: score_q};

endmodule
